// ===== rtl/aihtq_pkg.sv =====
// Shared types, constants and codes of the auxiliary input hold timer queue.
package aihtq_pkg;

    // Channel count and derived widths.
    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;
    localparam int CNT_W    = 3;

    // Field widths.
    localparam int TIME_W   = 48;
    localparam int CODE_W   = 64;
    localparam int HOLD_W   = 16;
    localparam int MSG_W    = 40;
    localparam int MTYPE_W  = 8;
    localparam int MNUM_W   = 16;
    localparam int MCRC_W   = 16;
    localparam int CIDX_W   = 8;
    localparam int CDATA_W  = 64;

    // Hold limit in milliseconds: hold seconds times one thousand.
    localparam int MS_PER_SECOND = 1000;
    localparam int LIM_W         = HOLD_W + 10;

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Edge result codes.
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_ENABLE = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_HOLD   = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_MSG0   = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_MSG3   = 8'd5;

    // Input word.
    typedef struct packed {
        logic              operation;
        logic [CH_W-1:0]   channel;
        logic              level;
        logic [TIME_W-1:0] time_ms;
        logic [CODE_W-1:0] prior_code;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]         edge_res;
        logic               running;
        logic [1:0]         action;
        logic [MTYPE_W-1:0] memory_type;
        logic [MNUM_W-1:0]  message_number;
        logic [MCRC_W-1:0]  message_crc;
        logic [CODE_W-1:0]  restore_code;
    } out_word_t;

    // Configuration write word.
    typedef struct packed {
        logic [CIDX_W-1:0]  index;
        logic [CDATA_W-1:0] wdata;
    } cfg_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sample_exec;
        logic pop;
        logic emit_front;
        logic emit_empty;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic fifo_empty;
        logic front_live;
    } ctrl_sts_t;

endpackage

// ===== rtl/aihtq_chan_if.sv =====
// Valid/ready channel interface that carries one word of a given type.
interface aihtq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aux_input_hold_timer_queue_unit.sv =====
// Top level of the auxiliary input hold timer queue.
//
// Channels: req takes one word per item (sample or poll), rsp returns one
// result word per item, cfg writes one register per word (index, data).
// A sample result is registered from the latched word once the output
// register is free. A poll first drops each dead or expired entry from the
// front of the trigger queue, then registers its result; the queue walk
// examines one front entry per cycle, and holds a live front or an empty
// queue until the output register is free. One item is in work at a time:
// req is ready again right after the result is registered, so the next
// word can be taken while the result still waits on rsp.
// If the receiver stalls, the result word holds in the output register and
// the next item finishes its work only when that register is free.
// Reset clears the hold and message settings, enables, channel state,
// queue count and saved code; the block takes words once reset is released. The cfg
// channel is always ready; writes are expected only while the block is idle.
module aux_input_hold_timer_queue_unit
    import aihtq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    aihtq_chan_if.sink   req,
    aihtq_chan_if.source rsp,
    aihtq_chan_if.sink   cfg
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    in_word_t  req_word;
    cfg_word_t cfg_word;
    out_word_t rsp_word;
    logic      req_ready_w;
    logic      rsp_valid_w;

    assign req_word  = req.data;
    assign cfg_word  = cfg.data;
    assign req.ready = req_ready_w;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_w;
    assign rsp.data  = rsp_word;

    // Sequencing of each item.
    aihtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req_word.operation),
        .req_ready (req_ready_w),
        .sts       (sts),
        .cmd       (cmd)
    );

    // State, queue and result register.
    aihtq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_word),
        .cfg_fire  (cfg.valid),
        .cfg_data  (cfg_word),
        .rsp_valid (rsp_valid_w),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_word)
    );

endmodule

// ===== rtl/aihtq_dp.sv =====
// Datapath: configuration registers, channel state, trigger queue and result register.
module aihtq_dp
    import aihtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    input  in_word_t  req_data,
    input  logic      cfg_fire,
    input  cfg_word_t cfg_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_word_t rsp_data
);

    // Configuration registers.
    logic [CHANNELS-1:0]              enable_reg, enable_next;
    logic [CHANNELS-1:0][HOLD_W-1:0]  hold_reg, hold_next;
    logic [CHANNELS-1:0][MSG_W-1:0]   msg_reg, msg_next;

    // Channel state.
    logic [CHANNELS-1:0]              level_reg, level_next;
    logic [CHANNELS-1:0]              running_reg, running_next;
    logic [TIME_W-1:0]                fall_reg [CHANNELS];
    logic [TIME_W-1:0]                fall_next [CHANNELS];

    // Trigger queue, saved code and last reported channel.
    logic [CH_W-1:0]                  fifo_reg [CHANNELS];
    logic [CH_W-1:0]                  fifo_next [CHANNELS];
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CODE_W-1:0]                saved_reg, saved_next;
    logic [CH_W-1:0]                  last_act_reg, last_act_next;
    logic                             last_vld_reg, last_vld_next;

    // Latched item and result register.
    in_word_t                         item_reg, item_next;
    out_word_t                        rsp_data_reg, rsp_data_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    // Front entry evaluation.
    logic [CH_W-1:0]                  fc;
    logic [TIME_W:0]                  diff;
    logic [LIM_W-1:0]                 limit;
    logic                             expired;
    logic                             found;
    logic [CH_W-1:0]                  sc;
    logic                             rise;
    logic                             fall;
    logic [CH_W-1:0]                  mk;

    // Expiry test of the queue front: low, running and past its hold time.
    always_comb
    begin
        fc      = fifo_reg[0];
        diff    = {1'b0, item_reg.time_ms} - {1'b0, fall_reg[fc]};
        limit   = LIM_W'(hold_reg[fc]) * LIM_W'(MS_PER_SECOND);
        expired = running_reg[fc] && !level_reg[fc] && !diff[TIME_W]
                  && (diff[TIME_W-1:0] > TIME_W'(limit));
    end

    // Edge detection of the latched sample.
    always_comb
    begin
        sc    = item_reg.channel;
        rise  = enable_reg[sc] && item_reg.level && !level_reg[sc];
        fall  = enable_reg[sc] && !item_reg.level && level_reg[sc];
        found = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (fifo_reg[i] == sc))
            begin
                found = 1'b1;
            end
        end
    end

    assign sts.out_free   = !rsp_valid_reg || rsp_ready;
    assign sts.fifo_empty = (count_reg == '0);
    assign sts.front_live = running_reg[fc] && !expired;

    // Next-state logic.
    always_comb
    begin
        enable_next    = enable_reg;
        hold_next      = hold_reg;
        msg_next       = msg_reg;
        level_next     = level_reg;
        running_next   = running_reg;
        fall_next      = fall_reg;
        fifo_next      = fifo_reg;
        count_next     = count_reg;
        saved_next     = saved_reg;
        last_act_next  = last_act_reg;
        last_vld_next  = last_vld_reg;
        item_next      = item_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mk             = '0;

        if (cmd.load)
        begin
            item_next = req_data;
        end

        // Sample: edge detect, queue an unqueued channel on a rising edge, stamp a falling edge.
        if (cmd.sample_exec)
        begin
            rsp_data_next  = '0;
            rsp_valid_next = 1'b1;
            if (rise)
            begin
                running_next[sc]   = 1'b1;
                level_next[sc]     = 1'b1;
                rsp_data_next.edge_res = EDGE_RISE;
                if (!found && (count_reg < CNT_W'(CHANNELS)))
                begin
                    if (count_reg == '0)
                    begin
                        saved_next = item_reg.prior_code;
                    end
                    fifo_next[count_reg[CH_W-1:0]] = sc;
                    count_next = count_reg + 1'b1;
                end
            end
            else if (fall)
            begin
                fall_next[sc]      = item_reg.time_ms;
                level_next[sc]     = 1'b0;
                rsp_data_next.edge_res = EDGE_FALL;
            end
        end

        // Drop the front entry; an expired channel stops running.
        if (cmd.pop)
        begin
            for (int i = 0; i < CHANNELS - 1; i++)
            begin
                fifo_next[i] = fifo_reg[i + 1];
            end
            count_next       = count_reg - 1'b1;
            running_next[fc] = 1'b0;
        end

        // Report the live front channel's message.
        if (cmd.emit_front)
        begin
            rsp_data_next                = '0;
            rsp_valid_next               = 1'b1;
            rsp_data_next.running        = 1'b1;
            rsp_data_next.memory_type    = msg_reg[fc][MSG_W-1 -: MTYPE_W];
            rsp_data_next.message_number = msg_reg[fc][MCRC_W +: MNUM_W];
            rsp_data_next.message_crc    = msg_reg[fc][MCRC_W-1:0];
            if (!last_vld_reg || (last_act_reg != fc))
            begin
                rsp_data_next.action = ACT_START;
                last_act_next        = fc;
                last_vld_next        = 1'b1;
            end
        end

        // Queue empty: hand back the saved code.
        if (cmd.emit_empty)
        begin
            rsp_data_next              = '0;
            rsp_valid_next             = 1'b1;
            rsp_data_next.restore_code = saved_reg;
            rsp_data_next.action       = last_vld_reg ? ACT_STOP : ACT_NONE;
            last_vld_next              = 1'b0;
            last_act_next              = '0;
        end

        // Configuration writes; a changed hold or message, or a cleared enable, cancels its channel.
        if (cfg_fire)
        begin
            case (cfg_data.index) inside
                CFG_ENABLE:
                begin
                    enable_next = cfg_data.wdata[CHANNELS-1:0];
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (!cfg_data.wdata[c])
                        begin
                            running_next[c] = 1'b0;
                            fall_next[c]    = '0;
                        end
                    end
                end
                CFG_HOLD:
                begin
                    hold_next = cfg_data.wdata;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (cfg_data.wdata[c*HOLD_W +: HOLD_W] != hold_reg[c])
                        begin
                            running_next[c] = 1'b0;
                            fall_next[c]    = '0;
                        end
                    end
                end
                [CFG_MSG0:CFG_MSG3]:
                begin
                    mk = CH_W'(cfg_data.index - CFG_MSG0);
                    if (msg_reg[mk] != cfg_data.wdata[MSG_W-1:0])
                    begin
                        msg_next[mk]     = cfg_data.wdata[MSG_W-1:0];
                        running_next[mk] = 1'b0;
                        fall_next[mk]    = '0;
                    end
                end
                default:
                begin
                    mk = '0;
                end
            endcase
        end
    end

    // Control and reset-cleared state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            hold_reg      <= '0;
            msg_reg       <= '0;
            level_reg     <= '0;
            running_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fall_reg[c] <= '0;
            end
            count_reg     <= '0;
            saved_reg     <= '0;
            last_act_reg  <= '0;
            last_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            hold_reg      <= hold_next;
            msg_reg       <= msg_next;
            level_reg     <= level_next;
            running_reg   <= running_next;
            fall_reg      <= fall_next;
            count_reg     <= count_next;
            saved_reg     <= saved_next;
            last_act_reg  <= last_act_next;
            last_vld_reg  <= last_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: item, queue entries, result word.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        fifo_reg     <= fifo_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The queue never holds more entries than there are channels.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CHANNELS))
        else $error("trigger queue count above channel count");

    // A pop only happens on a non-empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop on empty trigger queue");

    // A result is written only into a free result register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_front || cmd.emit_empty || cmd.sample_exec)
            |-> (!rsp_valid_reg || rsp_ready))
        else $error("result written over an untaken word");

endmodule

// ===== rtl/aihtq_ctrl.sv =====
// Controller: sequences sample updates and the queue walk of a poll.
module aihtq_ctrl
    import aihtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_op,
    output logic      req_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SAMPLE = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;

    logic [1:0] state_reg, state_next;

    // State transitions and command decode.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_op == OP_POLL) ? S_WALK : S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                if (sts.out_free)
                begin
                    cmd.sample_exec = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.fifo_empty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.front_live)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_front = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted word always leaves the idle state.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    // At most one datapath operation per cycle.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.sample_exec, cmd.pop, cmd.emit_front, cmd.emit_empty}))
        else $error("conflicting datapath commands");

    // Dropping a dead front keeps the walk going.
    a_pop_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (state_reg == S_WALK))
        else $error("queue walk ended after a pop");

endmodule
